FILE: rtl/vtp_pkg.sv
// Vertex transform and projection package: widths, register codes, payload types.
// Used by every other file of the block but vtp_stream_if; depends on nothing.
package vtp_pkg;

  localparam int CoordW    = 20;
  localparam int ScaleW    = 16;
  localparam int TrigW     = 16;
  localparam int TransW    = 60;
  localparam int GainW     = 24;
  localparam int ScrW      = 16;
  localparam int InvW      = 24;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 60;

  // growth of the coordinates through scale and the three rotations
  localparam int SclW  = 29;
  localparam int R1W   = 32;
  localparam int R2W   = 35;
  localparam int R3W   = 38;
  localparam int ViewW = 39;

  localparam int DefScreenW = 512;
  localparam int DefScreenH = 512;
  localparam int DefFifoDepth = 4;

  // divider: quotient bits kept, numerator and denominator widths
  localparam int QuoW   = 24;
  localparam int PrjNumW = 63;
  localparam int PrjDenW = 46;
  localparam int InvNumW = 25;
  localparam int InvDenW = 38;

  typedef enum logic [CfgIdxW-1:0] {
    CfgScale  = 3'd0,
    CfgRotXz  = 3'd1,
    CfgRotYz  = 3'd2,
    CfgRotXy  = 3'd3,
    CfgTrans  = 3'd4,
    CfgXGain  = 3'd5,
    CfgYGain  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [ScaleW-1:0]  scale_factor;
    logic [2*TrigW-1:0] rot_xz;
    logic [2*TrigW-1:0] rot_yz;
    logic [2*TrigW-1:0] rot_xy;
    logic [TransW-1:0]  translation;
    logic [GainW-1:0]   x_gain;
    logic [GainW-1:0]   y_gain;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    scale_factor: 16'd256,
    rot_xz:       32'h4000_0000,
    rot_yz:       32'h4000_0000,
    rot_xy:       32'h4000_0000,
    translation:  60'd0,
    x_gain:       24'd131072,
    y_gain:       24'd131072
  };

  typedef struct packed {
    logic signed [CoordW-1:0] model_x;
    logic signed [CoordW-1:0] model_y;
    logic signed [CoordW-1:0] model_z;
    logic                     last_in;
  } vertex_t;

  typedef struct packed {
    logic signed [ScrW-1:0] screen_x;
    logic signed [ScrW-1:0] screen_y;
    logic [InvW-1:0]        inv_depth;
    logic                   behind_camera;
    logic                   last_out;
  } pixel_t;

  // transformed vertex in view space, handed from front to back
  typedef struct packed {
    logic signed [ViewW-1:0] x;
    logic signed [ViewW-1:0] y;
    logic signed [ViewW-1:0] z;
    logic                    behind;
    logic                    last;
  } view_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: rtl/vtp_stream_if.sv
// Valid/ready stream channel carrying one payload item.
// Payload type is a parameter; types come from vtp_pkg.
interface vtp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/vtp_front.sv
// Front pipeline: scale, three plane rotations, translation, depth classification.
// Uses vtp_pkg types and vtp_stream_if; feeds vtp_fifo.
module vtp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vtp_pkg::cfg_t  cfg_i,
  vtp_stream_if.sink     in_vtx,
  input  logic           fifo_full_i,
  output logic           push_o,
  output vtp_pkg::view_t view_o
);

  logic       en;
  logic [4:0] val_q;

  logic signed [vtp_pkg::SclW-1:0]  x1_q, y1_q, z1_q;
  logic signed [vtp_pkg::R1W-1:0]   x2_q, z2_q;
  logic signed [vtp_pkg::SclW-1:0]  y2_q;
  logic signed [vtp_pkg::R1W-1:0]   x3_q;
  logic signed [vtp_pkg::R2W-1:0]   y3_q, z3_q;
  logic signed [vtp_pkg::R3W-1:0]   x4_q, y4_q;
  logic signed [vtp_pkg::R2W-1:0]   z4_q;
  logic [4:0]                       last_q;
  vtp_pkg::view_t                   view_q;

  logic signed [vtp_pkg::ScaleW:0]   sf;
  logic signed [36:0]                px_s, py_s, pz_s;
  logic signed [vtp_pkg::TrigW-1:0]  c1, s1, c2, s2, c3, s3;
  logic signed [45:0]                xz_x, xz_z;
  logic signed [48:0]                yz_y, yz_z;
  logic signed [51:0]                xy_x, xy_y;
  logic signed [vtp_pkg::ViewW-1:0]  vx, vy, vz;

  assign en           = !fifo_full_i;
  assign in_vtx.ready = en;

  assign sf   = $signed({1'b0, cfg_i.scale_factor});
  assign px_s = $signed(in_vtx.data.model_x) * sf;
  assign py_s = $signed(in_vtx.data.model_y) * sf;
  assign pz_s = $signed(in_vtx.data.model_z) * sf;

  assign c1 = $signed(cfg_i.rot_xz[31:16]);
  assign s1 = $signed(cfg_i.rot_xz[15:0]);
  assign c2 = $signed(cfg_i.rot_yz[31:16]);
  assign s2 = $signed(cfg_i.rot_yz[15:0]);
  assign c3 = $signed(cfg_i.rot_xy[31:16]);
  assign s3 = $signed(cfg_i.rot_xy[15:0]);

  assign xz_x = c1 * x1_q + s1 * z1_q;
  assign xz_z = c1 * z1_q - s1 * x1_q;
  assign yz_y = c2 * y2_q + s2 * z2_q;
  assign yz_z = c2 * z2_q - s2 * y2_q;
  assign xy_x = c3 * x3_q - s3 * y3_q;
  assign xy_y = c3 * y3_q + s3 * x3_q;

  assign vx = vtp_pkg::ViewW'(x4_q) + vtp_pkg::ViewW'($signed(cfg_i.translation[19:0]));
  assign vy = vtp_pkg::ViewW'(y4_q) + vtp_pkg::ViewW'($signed(cfg_i.translation[39:20]));
  assign vz = vtp_pkg::ViewW'(z4_q) + vtp_pkg::ViewW'($signed(cfg_i.translation[59:40]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (en) begin
      val_q <= {val_q[3:0], in_vtx.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // floor of the Q8.8 product: arithmetic shift drops the fraction
      x1_q <= px_s[36:8];
      y1_q <= py_s[36:8];
      z1_q <= pz_s[36:8];
      x2_q <= xz_x[45:14];
      z2_q <= xz_z[45:14];
      y2_q <= y1_q;
      x3_q <= x2_q;
      y3_q <= yz_y[48:14];
      z3_q <= yz_z[48:14];
      x4_q <= xy_x[51:14];
      y4_q <= xy_y[51:14];
      z4_q <= z3_q;
      last_q <= {last_q[3:0], in_vtx.data.last_in};
      view_q.x      <= vx;
      view_q.y      <= vy;
      view_q.z      <= vz;
      view_q.behind <= vz[vtp_pkg::ViewW-1] || (vz == '0);
      view_q.last   <= last_q[3];
    end
  end

  assign push_o = en && val_q[4];
  assign view_o = view_q;

endmodule

FILE: rtl/vtp_fifo.sv
// Small first-word-fall-through queue between front and back.
// Depends on vtp_pkg for the status struct.
module vtp_fifo #(
  parameter int  DEPTH = vtp_pkg::DefFifoDepth,
  parameter type T     = logic
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  T                    data_i,
  input  logic                pop_i,
  output T                    data_o,
  output vtp_pkg::fifo_stat_t stat_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/vtp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Takes its default widths from vtp_pkg; instantiated by vtp_back.
module vtp_div #(
  parameter int NW = vtp_pkg::PrjNumW,
  parameter int DW = vtp_pkg::PrjDenW,
  parameter int QW = vtp_pkg::QuoW
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o
);

  localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [NW-1:0] rem_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          ovf_q [QW+1];

  // overflow when the quotient would need more than QW bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= CW'(num_i) >= (CW'(den_i) << QW);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int Sh = QW - k;
    logic [CW-1:0] trial;
    logic          ge;

    assign trial = CW'(den_q[k-1]) << Sh;
    assign ge    = CW'(rem_q[k-1]) >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? rem_q[k-1] - NW'(trial) : rem_q[k-1];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= quo_q[k-1] | (ge ? (QW'(1) << Sh) : '0);
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

FILE: rtl/vtp_back.sv
// Back pipeline: projection gains, perspective divides, centering and saturation.
// Uses vtp_pkg, vtp_div and vtp_stream_if; drains vtp_fifo.
module vtp_back #(
  parameter int SCREEN_W = vtp_pkg::DefScreenW,
  parameter int SCREEN_H = vtp_pkg::DefScreenH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vtp_pkg::cfg_t       cfg_i,
  input  vtp_pkg::view_t      view_i,
  input  vtp_pkg::fifo_stat_t stat_i,
  output logic                pop_o,
  vtp_stream_if.source        out_pix
);

  localparam int QW    = vtp_pkg::QuoW;
  localparam int HalfW = SCREEN_W / 2;
  localparam int HalfH = SCREEN_H / 2;
  localparam int PW    = QW + 3;

  typedef struct packed {
    logic sgn_x;
    logic sgn_y;
    logic behind;
    logic last;
  } side_t;

  logic en;
  logic v1_q, v2_q, v3_q, out_v_q;
  logic dv_q [QW+1];
  side_t s1_q, s2_q, s3_q;
  side_t sd_q [QW+1];

  logic [vtp_pkg::ViewW-1:0]      ax1_q, ay1_q;
  logic [vtp_pkg::InvDenW-1:0]    z1_q, z2_q, z3_q;
  logic [43:0]                    pxl_q, pyl_q;
  logic [42:0]                    pxh_q, pyh_q;
  logic [vtp_pkg::PrjNumW-1:0]    nx3_q, ny3_q;
  logic [vtp_pkg::PrjDenW-1:0]    d3_q;

  logic [QW-1:0] qx, qy, qi;
  logic          ox, oy, oi;
  logic signed [PW-1:0] px, py, sx_w, sy_w;
  vtp_pkg::pixel_t      pix_d, pix_q;

  function automatic logic signed [vtp_pkg::ScrW-1:0] sat16(input logic signed [PW-1:0] v);
    if (v > PW'(32767)) begin
      return 16'sh7fff;
    end else if (v < -PW'(32768)) begin
      return -16'sh8000;
    end
    return v[vtp_pkg::ScrW-1:0];
  endfunction

  assign en    = !out_v_q || out_pix.ready;
  assign pop_o = en && !stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
      for (int k = 0; k <= QW; k++) begin
        dv_q[k] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= !stat_i.empty;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      dv_q[0] <= v3_q;
      for (int k = 1; k <= QW; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
      out_v_q <= dv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q <= view_i.x[vtp_pkg::ViewW-1] ? vtp_pkg::ViewW'(-view_i.x) : view_i.x;
      ay1_q <= view_i.y[vtp_pkg::ViewW-1] ? vtp_pkg::ViewW'(-view_i.y) : view_i.y;
      z1_q  <= view_i.z[vtp_pkg::InvDenW-1:0];
      s1_q  <= '{sgn_x: view_i.x[vtp_pkg::ViewW-1], sgn_y: view_i.y[vtp_pkg::ViewW-1],
                 behind: view_i.behind, last: view_i.last};
      // magnitude times gain split in two partial products
      pxl_q <= ax1_q[19:0] * cfg_i.x_gain;
      pxh_q <= ax1_q[38:20] * cfg_i.x_gain;
      pyl_q <= ay1_q[19:0] * cfg_i.y_gain;
      pyh_q <= ay1_q[38:20] * cfg_i.y_gain;
      z2_q  <= z1_q;
      s2_q  <= s1_q;
      nx3_q <= (vtp_pkg::PrjNumW'(pxh_q) << 20) + vtp_pkg::PrjNumW'(pxl_q);
      ny3_q <= (vtp_pkg::PrjNumW'(pyh_q) << 20) + vtp_pkg::PrjNumW'(pyl_q);
      d3_q  <= {z2_q, 8'd0};
      z3_q  <= z2_q;
      s3_q  <= s2_q;
      sd_q[0] <= s3_q;
      for (int k = 1; k <= QW; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
      pix_q <= pix_d;
    end
  end

  vtp_div #(.NW(vtp_pkg::PrjNumW), .DW(vtp_pkg::PrjDenW), .QW(QW)) u_div_x (
    .clk_i(clk_i), .en_i(en), .num_i(nx3_q), .den_i(d3_q), .quo_o(qx), .ovf_o(ox)
  );
  vtp_div #(.NW(vtp_pkg::PrjNumW), .DW(vtp_pkg::PrjDenW), .QW(QW)) u_div_y (
    .clk_i(clk_i), .en_i(en), .num_i(ny3_q), .den_i(d3_q), .quo_o(qy), .ovf_o(oy)
  );
  vtp_div #(.NW(vtp_pkg::InvNumW), .DW(vtp_pkg::InvDenW), .QW(QW)) u_div_inv (
    .clk_i(clk_i), .en_i(en), .num_i(vtp_pkg::InvNumW'(1) << QW), .den_i(z3_q),
    .quo_o(qi), .ovf_o(oi)
  );

  always_comb begin
    px   = sd_q[QW].sgn_x ? -PW'(qx) : PW'(qx);
    py   = sd_q[QW].sgn_y ? -PW'(qy) : PW'(qy);
    sx_w = px + PW'(HalfW);
    sy_w = PW'(HalfH) - py;
    pix_d.last_out      = sd_q[QW].last;
    pix_d.behind_camera = sd_q[QW].behind;
    if (sd_q[QW].behind) begin
      pix_d.screen_x  = '0;
      pix_d.screen_y  = '0;
      pix_d.inv_depth = '0;
    end else begin
      // a quotient past QW bits is far outside the screen range
      pix_d.screen_x  = ox ? (sd_q[QW].sgn_x ? -16'sh8000 : 16'sh7fff) : sat16(sx_w);
      pix_d.screen_y  = oy ? (sd_q[QW].sgn_y ? 16'sh7fff : -16'sh8000) : sat16(sy_w);
      pix_d.inv_depth = oi ? '1 : qi;
    end
  end

  assign out_pix.valid = out_v_q;
  assign out_pix.data  = pix_q;

endmodule

FILE: rtl/vertex_transform_project.sv
// Vertex transform and perspective projection, top level.
// Holds the configuration registers; builds on vtp_pkg, vtp_stream_if, vtp_front,
// vtp_fifo and vtp_back.
//
// in_vtx carries one model vertex per item, out_pix one projected pixel per item.
// Both are valid/ready channels; an item moves when valid and ready are high.
// Configuration goes through cfg_we_i/cfg_idx_i/cfg_data_i, one register per
// write; the user must write only while no vertex is in flight, which the
// block does not enforce. Unknown indexes are ignored. One vertex is accepted per
// cycle unless the queue is full. An accepted vertex passes five front stages
// (scale, three rotations, translate; the first one loads at the accepting edge),
// the queue, three back stages (magnitude, split gain multiply, sum), QuoW+1
// divider stages (overflow check, one quotient bit each) and the output register.
// When out_pix stalls, the back pipeline freezes; the front keeps filling the
// queue (FIFO_DEPTH items) and drops in_vtx.ready once it is full.
// Reset clears all valid bits and loads scale 1.0, identity rotations, zero
// translation and gains of 512.0; no clearing pass is needed.
module vertex_transform_project #(
  parameter int SCREEN_W   = vtp_pkg::DefScreenW,
  parameter int SCREEN_H   = vtp_pkg::DefScreenH,
  parameter int FIFO_DEPTH = vtp_pkg::DefFifoDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vtp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [vtp_pkg::CfgDataW-1:0]  cfg_data_i,
  vtp_stream_if.sink                    in_vtx,
  vtp_stream_if.source                  out_pix
);

  vtp_pkg::cfg_t       cfg_q;
  vtp_pkg::view_t      push_data, pop_data;
  vtp_pkg::fifo_stat_t fifo_stat;
  logic                push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= vtp_pkg::CfgReset;
    end else if (cfg_we_i) begin
      unique case (vtp_pkg::cfg_idx_e'(cfg_idx_i))
        vtp_pkg::CfgScale: cfg_q.scale_factor <= cfg_data_i[15:0];
        vtp_pkg::CfgRotXz: cfg_q.rot_xz       <= cfg_data_i[31:0];
        vtp_pkg::CfgRotYz: cfg_q.rot_yz       <= cfg_data_i[31:0];
        vtp_pkg::CfgRotXy: cfg_q.rot_xy       <= cfg_data_i[31:0];
        vtp_pkg::CfgTrans: cfg_q.translation  <= cfg_data_i[59:0];
        vtp_pkg::CfgXGain: cfg_q.x_gain       <= cfg_data_i[23:0];
        vtp_pkg::CfgYGain: cfg_q.y_gain       <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  vtp_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_q), .in_vtx(in_vtx),
    .fifo_full_i(fifo_stat.full), .push_o(push), .view_o(push_data)
  );

  vtp_fifo #(.DEPTH(FIFO_DEPTH), .T(vtp_pkg::view_t)) u_fifo (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .data_i(push_data),
    .pop_i(pop), .data_o(pop_data), .stat_o(fifo_stat)
  );

  vtp_back #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_q), .view_i(pop_data),
    .stat_i(fifo_stat), .pop_o(pop), .out_pix(out_pix)
  );

`ifndef SYNTHESIS
  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_stat.full)
    else $error("front pushed into full queue");

  // vertices behind the camera come out with zeroed fields
  a_behind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_pix.valid && out_pix.data.behind_camera) |->
      (out_pix.data.screen_x == '0 && out_pix.data.screen_y == '0 &&
       out_pix.data.inv_depth == '0))
    else $error("behind-camera item with nonzero fields");
`endif

endmodule
